// File: hw/rtl/rhb_pkg.sv
// Shared types and constants for the range histogram binner.
package rhb_pkg;

    // Item kinds carried on the input tuser field.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DUMP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes and the APB address width.
    localparam int         ADDR_W          = 4;
    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_RANGE_END   = 2'd1;
    localparam logic [1:0] REG_BIN_COUNT   = 2'd2;

    localparam logic [15:0] RANGE_START_RST = 16'sd0;
    localparam logic [15:0] RANGE_END_RST   = 16'sd32767;
    localparam logic [6:0]  BIN_COUNT_RST   = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_sample;
        logic calc;
        logic div_step;
        logic rd_sample;
        logic upd;
        logic clear;
        logic dump_first;
        logic rd_dump;
        logic dump_next;
        logic load_out;
    } rhb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic dump_last;
    } rhb_status_t;

endpackage

// File: hw/rtl/rhb_regs.sv
// APB configuration registers: range start, range end and bin count.
module rhb_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rhb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic signed [15:0]        range_start,
    output logic signed [15:0]        range_end,
    output logic [6:0]                bin_count
);
    import rhb_pkg::*;

    logic [15:0] range_start_reg;
    logic [15:0] range_end_reg;
    logic [6:0]  bin_count_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= RANGE_START_RST;
            range_end_reg   <= RANGE_END_RST;
            bin_count_reg   <= BIN_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RANGE_START: range_start_reg <= pwdata[15:0];
                REG_RANGE_END:   range_end_reg   <= pwdata[15:0];
                REG_BIN_COUNT:   bin_count_reg   <= pwdata[6:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RANGE_START: prdata = {16'd0, range_start_reg};
            REG_RANGE_END:   prdata = {16'd0, range_end_reg};
            REG_BIN_COUNT:   prdata = {25'd0, bin_count_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign range_start = signed'(range_start_reg);
    assign range_end   = signed'(range_end_reg);
    assign bin_count   = bin_count_reg;

endmodule

// File: hw/rtl/rhb_datapath.sv
// Datapath: range check, bin index divider, count store, peak and output register.
module rhb_datapath
#(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rhb_pkg::rhb_cmd_t    cmd,
    output rhb_pkg::rhb_status_t status,
    input  logic [15:0]          sample_value,
    input  logic signed [15:0]   range_start,
    input  logic signed [15:0]   range_end,
    input  logic [6:0]           bin_count,
    output logic [5:0]           bin_index,
    output logic [31:0]          bin_total,
    output logic [31:0]          peak_total,
    output logic                 last_bin
);
    import rhb_pkg::*;

    localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS + 1);
    localparam int PROD_W = 16 + BIN_W;

    logic [15:0]           sample_reg;
    logic [PROD_W-1:0]     rem_reg;
    logic [PROD_W-1:0]     dsr_reg;
    logic [IDX_W-1:0]      quo_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0]   valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [5:0]            out_index_reg;
    logic [31:0]           out_total_reg;
    logic [31:0]           out_peak_reg;
    logic                  out_last_reg;

    logic [BIN_W-1:0]      bins_act;
    logic [16:0]           off_wide;
    logic [16:0]           span_wide;
    logic [PROD_W-1:0]     product;
    logic                  ge;
    logic [IDX_W:0]        quo_shift;
    logic [IDX_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [31:0]           total_sat;
    logic [31:0]           peak_sat;

    // Bin count zero means one bin; anything above the store depth is clamped.
    always_comb
    begin
        if (bin_count == 7'd0)
            bins_act = BIN_W'(1);
        else if (bin_count > 7'(MAX_BINS))
            bins_act = BIN_W'(MAX_BINS);
        else
            bins_act = bin_count[BIN_W-1:0];
    end

    assign off_wide  = {sample_reg[15], sample_reg} - {range_start[15], range_start};
    assign span_wide = {range_end[15], range_end} - {range_start[15], range_start};
    assign product   = PROD_W'(off_wide[15:0]) * PROD_W'(bins_act);

    assign status.in_range = (range_end > range_start)
                          && (signed'(sample_reg) >= range_start)
                          && (signed'(sample_reg) < range_end);
    assign status.dump_last = (BIN_W'(cnt_reg) == (bins_act - BIN_W'(1)));

    // One quotient bit per step; the quotient is below the bin count.
    assign ge        = (rem_reg >= dsr_reg);
    assign quo_shift = {quo_reg, ge};

    assign rd_addr = cmd.rd_dump ? cnt_reg : quo_reg;
    assign cnt_cur = rd_valid_reg ? rd_data_reg : '0;
    assign cnt_new = (cnt_cur == {COUNT_BITS{1'b1}}) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

    generate
        if (COUNT_BITS > 32)
        begin : g_sat
            assign total_sat = (|cnt_cur[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : cnt_cur[31:0];
            assign peak_sat  = (|peak_reg[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : peak_reg[31:0];
        end
        else
        begin : g_ext
            assign total_sat = 32'(cnt_cur);
            assign peak_sat  = 32'(peak_reg);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
            sample_reg <= sample_value;
        if (cmd.calc)
        begin
            rem_reg <= product;
            dsr_reg <= PROD_W'(span_wide[15:0]) << (IDX_W - 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
                rem_reg <= rem_reg - dsr_reg;
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= quo_shift[IDX_W-1:0];
        end
        if (cmd.rd_sample || cmd.rd_dump)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.load_out)
        begin
            out_index_reg <= 6'(cnt_reg);
            out_total_reg <= total_sat;
            out_peak_reg  <= peak_sat;
            out_last_reg  <= status.dump_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            mem[quo_reg] <= cnt_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            peak_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
                peak_reg  <= '0;
            end
            else if (cmd.upd)
            begin
                valid_reg[quo_reg] <= 1'b1;
                if (cnt_new > peak_reg)
                    peak_reg <= cnt_new;
            end
            if (cmd.dump_first)
                cnt_reg <= '0;
            else if (cmd.dump_next)
                cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    assign bin_index  = out_index_reg;
    assign bin_total  = out_total_reg;
    assign peak_total = out_peak_reg;
    assign last_bin   = out_last_reg;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (BIN_W'(quo_reg) < bins_act))
        else $error("bin index from divider is outside the active bins");

    a_clear_peak: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (peak_reg == '0))
        else $error("peak not zero after clear");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear |=> (peak_reg >= $past(peak_reg)))
        else $error("peak decreased without a clear");
`endif

endmodule

// File: hw/rtl/rhb_ctrl.sv
// Controller state machine sequencing samples, dumps and clears.
module rhb_ctrl
#(
    parameter int MAX_BINS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           kind,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  rhb_pkg::rhb_status_t status,
    output rhb_pkg::rhb_cmd_t    cmd
);
    import rhb_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CALC    = 7'b0000010,
        ST_DIV     = 7'b0000100,
        ST_READ    = 7'b0001000,
        ST_UPD     = 7'b0010000,
        ST_DUMP_RD = 7'b0100000,
        ST_DUMP_LD = 7'b1000000
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [SW-1:0]  step_reg;
    logic [SW-1:0]  step_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (kind)
                        KIND_SAMPLE:
                        begin
                            cmd.take_sample = 1'b1;
                            state_next      = ST_CALC;
                        end
                        KIND_DUMP:
                        begin
                            cmd.dump_first = 1'b1;
                            state_next     = ST_DUMP_RD;
                        end
                        KIND_CLEAR: cmd.clear = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_CALC:
            begin
                cmd.calc  = 1'b1;
                step_next = SW'(IDX_W - 1);
                state_next = status.in_range ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - SW'(1);
                if (step_reg == '0)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_sample = 1'b1;
                state_next    = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DUMP_RD:
            begin
                cmd.rd_dump = 1'b1;
                state_next  = ST_DUMP_LD;
            end
            ST_DUMP_LD:
            begin
                // The previous bin must have left the output register first.
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.dump_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.dump_next = 1'b1;
                        state_next    = ST_DUMP_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");

    a_next_bin_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_next |=> cmd.rd_dump)
        else $error("dump advanced without reading the next bin");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.upd || cmd.rd_dump) |-> !s_tready)
        else $error("new request accepted while an item is in work");
`endif

endmodule

// File: hw/rtl/range_histogram_binner.sv
// Sample in range: after acceptance come the check, 6 divider steps, a read and a write,
// the bit-serial divider giving one quotient bit per cycle; out of range it returns to idle after the check.
// Dump item: each bin is read from the count store, then loaded once the output register is free.
// Clear and unused items are handled in idle; the request after a dump's last bin is taken at once.
// Reset is asynchronous, active low; per-bin valid flops zero every count immediately.
// Configuration registers reset to start 0, end 32767, 64 bins.
module range_histogram_binner
#(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [15:0] sample_value
    input  logic [1:0]                s_tuser,   // [1:0] kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata,   // [5:0] bin_index, [37:6] bin_total,
                                                 // [69:38] peak_total, [71:70] zero
    output logic                      m_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rhb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rhb_pkg::*;

    rhb_cmd_t           cmd;
    rhb_status_t        status;
    logic signed [15:0] range_start;
    logic signed [15:0] range_end;
    logic [6:0]         bin_count;
    logic [5:0]         bin_index;
    logic [31:0]        bin_total;
    logic [31:0]        peak_total;

    rhb_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .range_start (range_start),
        .range_end   (range_end),
        .bin_count   (bin_count)
    );

    rhb_ctrl #(.MAX_BINS(MAX_BINS)) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhb_datapath #(.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_value (s_tdata),
        .range_start  (range_start),
        .range_end    (range_end),
        .bin_count    (bin_count),
        .bin_index    (bin_index),
        .bin_total    (bin_total),
        .peak_total   (peak_total),
        .last_bin     (m_tlast)
    );

    assign m_tdata = {2'b00, peak_total, bin_total, bin_index};

endmodule
